// ===== src/pcrd_pkg.sv =====
// shared types, constants and command/status structs of the pulse class run detector
package pcrd_pkg;

    localparam int CLASSES_PER_LEVEL = 3;
    localparam int NUM_SLOTS         = 2 * CLASSES_PER_LEVEL;
    localparam int CLS_W             = (CLASSES_PER_LEVEL > 1) ? $clog2(CLASSES_PER_LEVEL) : 1;
    localparam int SLOT_W            = $clog2(NUM_SLOTS);

    localparam int DUR_W      = 16;
    localparam int CNT_W      = 9;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = ((1 + DUR_W) + 7) / 8 * 8;
    localparam int M_TDATA_W = ((CNT_W + DUR_W) + 7) / 8 * 8;

    localparam int DVD_W     = DUR_W + CNT_W + 1;
    localparam int DVS_W     = CNT_W + 1;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam logic [CNT_W-1:0] MIN_MEMBERS = CNT_W'(3);
    localparam logic [CNT_W-1:0] COUNT_MAX   = '1;

    localparam logic [DUR_W-1:0] MIN_DUR_RESET = DUR_W'(40);
    localparam logic [DUR_W-1:0] MAX_DUR_RESET = DUR_W'(4000);
    localparam logic [CNT_W-1:0] MAX_RUN_RESET = CNT_W'(500);

    typedef enum logic [STAT_W-1:0] {
        STS_ACCEPTED  = 3'd0,
        STS_OUT_RANGE = 3'd1,
        STS_NO_CLASS  = 3'd2,
        STS_FULL      = 3'd3,
        STS_IDLE      = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DUR = 2'd0,
        CFG_MAX_DUR = 2'd1,
        CFG_MAX_RUN = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_DIV,
        S_WRITE,
        S_EST,
        S_OUT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    end_run;
        logic    set_status;
        status_t status;
        logic    scan_clear;
        logic    scan_next;
        logic    fill_slot;
        logic    mul;
        logic    div_step;
        logic    write_avg;
        logic    est;
        logic    out_load;
    } pcrd_cmd_t;

    typedef struct packed {
        logic run_active;
        logic run_full;
        logic out_of_range;
        logic slot_empty;
        logic slot_match;
        logic last_class;
        logic div_last;
        logic out_free;
    } pcrd_stat_t;

endpackage

// ===== src/pulse_class_run_detector_core.sv =====
// top level of the pulse class run detector
// Each pulse is classified by level into up to three duration classes and answered with one
// result: status, run length and short-pulse estimate. One pulse is handled at a time; a new
// pulse is taken while the previous result still waits on the output register. A pulse that ends
// the run, arrives idle, or opens an empty class passes the check, the class scan (skipped when
// the run ends before the scan), the estimate and the output stage; a pulse that joins an
// existing class also passes the 26-step restoring divider that forms the new weighted average.
// The output stage waits on m_tready while the result register is full. Configuration writes are
// always ready and take effect on the next cycle.
module pulse_class_run_detector_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pcrd_pkg::S_TDATA_W-1:0]   s_tdata,   // level, duration, zero pad
    input  logic [0:0]                       s_tuser,   // start_req
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pcrd_pkg::M_TDATA_W-1:0]   m_tdata,   // run_length, short_pulse, zero pad
    output logic [pcrd_pkg::STAT_W-1:0]      m_tuser,   // status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pcrd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcrd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pcrd_pkg::*;

    pcrd_cmd_t  cmd;
    pcrd_stat_t stat;

    assign cfg_ready = 1'b1;

    pcrd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcrd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== src/pcrd_ctrl.sv =====
// controller state machine sequencing one pulse through check, class scan, divide and report
module pcrd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pcrd_pkg::pcrd_stat_t stat,
    output pcrd_pkg::pcrd_cmd_t  cmd
);
    import pcrd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STS_ACCEPTED;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next     = S_EST;
                cmd.set_status = 1'b1;
                if (!stat.run_active) begin
                    cmd.status = STS_IDLE;
                end else if (stat.run_full) begin
                    cmd.status  = STS_FULL;
                    cmd.end_run = 1'b1;
                end else if (stat.out_of_range) begin
                    cmd.status  = STS_OUT_RANGE;
                    cmd.end_run = 1'b1;
                end else begin
                    cmd.set_status = 1'b0;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (stat.slot_empty) begin
                    cmd.fill_slot  = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = STS_ACCEPTED;
                    state_next     = S_EST;
                end else if (stat.slot_match) begin
                    cmd.mul    = 1'b1;
                    state_next = S_DIV;
                end else if (stat.last_class) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = STS_NO_CLASS;
                    cmd.end_run    = 1'b1;
                    state_next     = S_EST;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.write_avg  = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = STS_ACCEPTED;
                state_next     = S_EST;
            end
            S_EST: begin
                cmd.est    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a pulse is in progress");

    a_out_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result register overwritten");

    a_div_runs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && !stat.div_last |=> state_reg == S_DIV)
        else $error("divide left early");

endmodule

// ===== src/pcrd_dp.sv =====
// datapath: configuration, class store, class scan, restoring divider, estimate and result register
module pcrd_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pcrd_pkg::pcrd_cmd_t                 cmd,
    output pcrd_pkg::pcrd_stat_t                stat,
    input  logic [0:0]                          s_tuser,
    input  logic [pcrd_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                cfg_valid,
    input  logic [pcrd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcrd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pcrd_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [pcrd_pkg::STAT_W-1:0]         m_tuser
);
    import pcrd_pkg::*;

    logic [DUR_W-1:0] min_dur_reg;
    logic [DUR_W-1:0] max_dur_reg;
    logic [CNT_W-1:0] max_run_reg;

    logic [DUR_W-1:0] avg_reg     [NUM_SLOTS];
    logic [CNT_W-1:0] members_reg [NUM_SLOTS];
    logic [CNT_W-1:0] count_reg;
    logic             run_active_reg;

    logic             lvl_reg;
    logic [DUR_W-1:0] dur_reg;
    logic [CLS_W-1:0] k_reg;

    logic [DVD_W-1:0]     dvd_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [DUR_W-1:0] best_lo_reg;
    logic [DUR_W-1:0] best_hi_reg;

    status_t          status_reg;
    logic             m_tvalid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [CNT_W-1:0] m_len_reg;
    logic [DUR_W-1:0] m_short_reg;

    logic [SLOT_W-1:0]       slot;
    logic [DUR_W-1:0]        slot_avg;
    logic [CNT_W-1:0]        slot_cnt;
    logic [DUR_W-1:0]        delta;
    logic [DUR_W+CNT_W-1:0]  prod;
    logic [DVS_W:0]          rem_sh;
    logic                    q_bit;
    logic [DVS_W:0]          rem_diff;
    logic [DUR_W-1:0]        best_next [2];
    logic [DUR_W-1:0]        b_lo;
    logic [DUR_W-1:0]        b_hi;
    logic [DUR_W:0]          est_sum;
    logic                    out_free;

    assign slot = SLOT_W'(lvl_reg) * SLOT_W'(CLASSES_PER_LEVEL) + SLOT_W'(k_reg);
    assign slot_avg = avg_reg[slot];
    assign slot_cnt = members_reg[slot];
    assign delta = (dur_reg > slot_avg) ? (dur_reg - slot_avg) : (slot_avg - dur_reg);
    assign prod = slot_avg * slot_cnt;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign q_bit    = (rem_sh >= {1'b0, dvs_reg});

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        stat              = '0;
        stat.run_active   = run_active_reg;
        stat.run_full     = (count_reg >= max_run_reg);
        stat.out_of_range = (dur_reg < min_dur_reg) || (dur_reg > max_dur_reg);
        stat.slot_empty   = (slot_cnt == '0);
        stat.slot_match   = (delta < (slot_avg >> 3));
        stat.last_class   = (k_reg == CLS_W'(CLASSES_PER_LEVEL - 1));
        stat.div_last     = (div_cnt_reg == DIV_CNT_W'(DVD_W - 1));
        stat.out_free     = out_free;
    end

    // smallest well populated class average per level
    always_comb begin
        for (int lv = 0; lv < 2; lv++) begin
            best_next[lv] = '0;
            for (int c = 0; c < CLASSES_PER_LEVEL; c++) begin
                if (avg_reg[lv * CLASSES_PER_LEVEL + c] != '0 &&
                    members_reg[lv * CLASSES_PER_LEVEL + c] >= MIN_MEMBERS &&
                    (best_next[lv] == '0 ||
                     avg_reg[lv * CLASSES_PER_LEVEL + c] < best_next[lv])) begin
                    best_next[lv] = avg_reg[lv * CLASSES_PER_LEVEL + c];
                end
            end
        end
    end

    assign b_lo    = (best_lo_reg == '0) ? best_hi_reg : best_lo_reg;
    assign b_hi    = (best_hi_reg == '0) ? best_lo_reg : best_hi_reg;
    assign est_sum = {1'b0, b_lo} + {1'b0, b_hi};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dur_reg <= MIN_DUR_RESET;
            max_dur_reg <= MAX_DUR_RESET;
            max_run_reg <= MAX_RUN_RESET;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_DUR: min_dur_reg <= cfg_data;
                CFG_MAX_DUR: max_dur_reg <= cfg_data;
                CFG_MAX_RUN: max_run_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                avg_reg[i]     <= '0;
                members_reg[i] <= '0;
            end
            count_reg      <= '0;
            run_active_reg <= 1'b0;
        end else begin
            if (cmd.load && s_tuser[0]) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    avg_reg[i]     <= '0;
                    members_reg[i] <= '0;
                end
                count_reg      <= '0;
                run_active_reg <= 1'b1;
            end
            if (cmd.end_run) begin
                run_active_reg <= 1'b0;
            end
            if (cmd.fill_slot) begin
                avg_reg[slot]     <= dur_reg;
                members_reg[slot] <= CNT_W'(1);
            end
            if (cmd.write_avg) begin
                avg_reg[slot] <= dvd_reg[DUR_W-1:0];
                if (slot_cnt != COUNT_MAX) begin
                    members_reg[slot] <= slot_cnt + CNT_W'(1);
                end
            end
            if ((cmd.fill_slot || cmd.write_avg) && count_reg != COUNT_MAX) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lvl_reg <= s_tdata[0];
            dur_reg <= s_tdata[DUR_W:1];
        end
        if (cmd.scan_clear) begin
            k_reg <= '0;
        end else if (cmd.scan_next) begin
            k_reg <= k_reg + CLS_W'(1);
        end
        if (cmd.mul) begin
            dvd_reg     <= DVD_W'(prod) + DVD_W'(dur_reg);
            dvs_reg     <= DVS_W'(slot_cnt) + DVS_W'(1);
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= q_bit ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            dvd_reg     <= {dvd_reg[DVD_W-2:0], q_bit};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.est) begin
            best_lo_reg <= best_next[0];
            best_hi_reg <= best_next[1];
        end
        if (cmd.out_load) begin
            m_status_reg <= status_reg;
            m_len_reg    <= count_reg;
            m_short_reg  <= est_sum[DUR_W:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_TDATA_W'({m_short_reg, m_len_reg});

    a_run_starts_on_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(run_active_reg) |-> $past(cmd.load && s_tuser[0]))
        else $error("run became active without a start request");

    a_quotient_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_avg |-> dvd_reg[DVD_W-1:DUR_W] == '0)
        else $error("weighted mean wider than a duration");

    a_joined_class_populated: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fill_slot || cmd.write_avg |=> members_reg[$past(slot)] != '0)
        else $error("joined class has no members");

endmodule
